/* rtl/core/sfi_pkg.sv */
// ----------------------------------------------------------------------------
// sfi_pkg
// Shared types and constants of the stream frame indexer: result record,
// front-to-queue emit bundle, status codes and frame layout constants.
// ----------------------------------------------------------------------------
package sfi_pkg;

    // frame layout
    localparam int HDR_LEN   = 16;
    localparam int HDR_IW    = $clog2(HDR_LEN);
    localparam int KEY_SKIP  = 1040;
    localparam int TAIL_LEN  = 1024;
    localparam logic [7:0] TYPE_KEY  = 8'hF2;
    localparam logic [7:0] TYPE_SKIP = 8'hF0;

    // result kinds
    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // final status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOKEY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_ABORT = 2'd3;

    // configuration register indexes
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_BEGIN_OFFSET  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_STREAM_LENGTH = 1'b1;

    // result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [31:0] position;
        logic [31:0] frame_time;
        logic [1:0]  status;
        logic [31:0] count;
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic        last_of_run;
    } t_result;

    // what the parser hands to the queue for one byte
    typedef struct packed {
        logic    entry_v;
        logic    final_v;
        t_result entry;
        t_result fin;
    } t_emit;

endpackage

/* rtl/core/sfi_front.sv */
// ----------------------------------------------------------------------------
// sfi_front
// Byte parser: tracks file position, collects frame headers, classifies
// them and produces index entry and final status records.
// ----------------------------------------------------------------------------
module sfi_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_first_byte,
    input  logic           i_last_byte,
    input  logic           i_abort,
    input  logic [31:0]    i_begin_offset,
    input  logic [31:0]    i_stream_length,
    output sfi_pkg::t_emit o_emit
);
    import sfi_pkg::*;

    logic [31:0]       r_pos, n_pos;
    logic [31:0]       r_hs, n_hs;
    logic [31:0]       r_nfs, n_nfs;
    logic [HDR_IW-1:0] r_hidx, n_hidx;
    logic [31:0]       r_ent, n_ent;
    logic [31:0]       r_ear, n_ear;
    logic [31:0]       r_lat, n_lat;
    logic              r_fin, n_fin;
    logic [7:0]        r_hdr [HDR_LEN];

    logic [31:0]       e_pos, e_hs, e_nfs, e_ent, e_ear, e_lat;
    logic [HDR_IW-1:0] e_hidx;
    logic              e_fin;
    logic              al_frame, in_hdr, hdr_we, p_end, tail, code_ok;
    logic              entry_v, final_v, chk;
    logic [1:0]        fstat;
    logic [31:0]       tword;
    logic [15:0]       lenf;
    logic [32:0]       nxt;
    logic [33:0]       len34;

    // state as seen by this byte: a new file starts from cleared state
    always_comb begin
        e_pos  = i_first_byte ? i_begin_offset : r_pos;
        e_nfs  = i_first_byte ? i_begin_offset : r_nfs;
        e_hs   = i_first_byte ? '0 : r_hs;
        e_hidx = i_first_byte ? '0 : r_hidx;
        e_ent  = i_first_byte ? '0 : r_ent;
        e_ear  = i_first_byte ? '0 : r_ear;
        e_lat  = i_first_byte ? '0 : r_lat;
        e_fin  = i_first_byte ? 1'b0 : r_fin;
    end

    // header fields and end-of-data compares
    always_comb begin
        len34    = {2'b00, i_stream_length};
        al_frame = (e_hidx == '0) && (e_pos == e_nfs);
        in_hdr   = (e_hidx != '0) || (e_pos == e_nfs);
        p_end    = ({2'b00, e_pos} + 34'(HDR_LEN)) > len34;
        tail     = ({2'b00, e_hs} + 34'(TAIL_LEN)) > len34;
        code_ok  = (r_hdr[0] == 8'h00) && (r_hdr[1] == 8'h00) && (r_hdr[2] == 8'h01);
        tword    = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
        lenf     = {r_hdr[7], r_hdr[6]};
    end

    // per-byte parse step
    always_comb begin
        n_pos   = r_pos;
        n_hs    = r_hs;
        n_nfs   = r_nfs;
        n_hidx  = r_hidx;
        n_ent   = r_ent;
        n_ear   = r_ear;
        n_lat   = r_lat;
        n_fin   = r_fin;
        entry_v = 1'b0;
        final_v = 1'b0;
        fstat   = ST_OK;
        hdr_we  = 1'b0;
        chk     = 1'b0;
        nxt     = '0;
        if (i_valid) begin
            n_pos  = e_pos;
            n_hs   = e_hs;
            n_nfs  = e_nfs;
            n_hidx = e_hidx;
            n_ent  = e_ent;
            n_ear  = e_ear;
            n_lat  = e_lat;
            n_fin  = e_fin;
            if (!e_fin) begin
                if (i_abort) begin
                    final_v = 1'b1;
                    fstat   = ST_ABORT;
                end else if (al_frame && p_end) begin
                    final_v = 1'b1;
                    fstat   = (e_ent != '0) ? ST_OK : ST_NOKEY;
                end else begin
                    if (in_hdr) begin
                        hdr_we = 1'b1;
                        n_hidx = e_hidx + HDR_IW'(1);
                        if (e_hidx == '0) begin
                            n_hs = e_pos;
                        end
                        // header complete on its last byte
                        if (e_hidx == HDR_IW'(HDR_LEN - 1)) begin
                            if (!code_ok) begin
                                final_v = 1'b1;
                                fstat   = tail ? ((e_ent != '0) ? ST_OK : ST_NOKEY)
                                               : ST_BAD;
                            end else if (r_hdr[3] == TYPE_KEY) begin
                                entry_v = 1'b1;
                                n_ear   = (e_ent == '0) ? tword : e_ear;
                                n_lat   = tword;
                                n_ent   = (e_ent == '1) ? e_ent : e_ent + 32'd1;
                                chk     = 1'b1;
                                nxt     = {1'b0, e_hs} + 33'(KEY_SKIP);
                            end else if (r_hdr[3] == TYPE_SKIP) begin
                                chk = 1'b1;
                                nxt = {1'b0, e_hs} + 33'(HDR_LEN) + {17'd0, lenf};
                            end else begin
                                final_v = 1'b1;
                                fstat   = ST_BAD;
                            end
                            if (chk) begin
                                if (({1'b0, nxt} + 34'(HDR_LEN)) > len34) begin
                                    final_v = 1'b1;
                                    fstat   = (n_ent != '0) ? ST_OK : ST_NOKEY;
                                end else begin
                                    n_nfs = nxt[31:0];
                                end
                            end
                        end
                    end
                    n_pos = e_pos + 32'd1;
                    if (!final_v && i_last_byte) begin
                        final_v = 1'b1;
                        fstat   = (n_ent != '0) ? ST_OK : ST_NOKEY;
                    end
                end
                if (final_v) begin
                    n_fin = 1'b1;
                end
            end
        end
    end

    // result records
    always_comb begin
        o_emit.entry_v                = entry_v;
        o_emit.final_v                = final_v;
        o_emit.entry.kind             = KIND_ENTRY;
        o_emit.entry.position         = e_hs;
        o_emit.entry.frame_time       = tword;
        o_emit.entry.status           = ST_OK;
        o_emit.entry.count            = n_ent;
        o_emit.entry.first_time       = '0;
        o_emit.entry.last_time        = '0;
        o_emit.entry.last_of_run      = !final_v;
        o_emit.fin.kind               = KIND_FINAL;
        o_emit.fin.position           = '0;
        o_emit.fin.frame_time         = '0;
        o_emit.fin.status             = fstat;
        o_emit.fin.count              = n_ent;
        o_emit.fin.first_time         = n_ear;
        o_emit.fin.last_time          = n_lat;
        o_emit.fin.last_of_run        = 1'b1;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hs   <= '0;
            r_nfs  <= '0;
            r_hidx <= '0;
            r_ent  <= '0;
            r_ear  <= '0;
            r_lat  <= '0;
            r_fin  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_hs   <= n_hs;
            r_nfs  <= n_nfs;
            r_hidx <= n_hidx;
            r_ent  <= n_ent;
            r_ear  <= n_ear;
            r_lat  <= n_lat;
            r_fin  <= n_fin;
        end
    end

    // header byte capture
    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[e_hidx] <= i_data_byte;
        end
    end

endmodule

/* rtl/core/sfi_rq.sv */
// ----------------------------------------------------------------------------
// sfi_rq
// Result queue between parser and result port: takes up to two records a
// cycle, hands out one record a beat from its head.
// ----------------------------------------------------------------------------
module sfi_rq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfi_pkg::t_emit   i_emit,
    input  logic             i_pop,
    output sfi_pkg::t_result o_head,
    output logic             o_empty,
    output logic             o_full
);
    import sfi_pkg::*;

    t_result          r_q [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp, n_wp;
    logic [RQ_AW-1:0] r_rp, n_rp;
    logic [RQ_CW-1:0] r_cnt, n_cnt;
    logic [RQ_AW-1:0] wp1;
    logic             w0, w1, pop;
    t_result          rec0;

    // compact the emit bundle into one or two consecutive slots
    always_comb begin
        w0   = i_emit.entry_v || i_emit.final_v;
        w1   = i_emit.entry_v && i_emit.final_v;
        rec0 = i_emit.entry_v ? i_emit.entry : i_emit.fin;
        wp1  = r_wp + RQ_AW'(1);
        pop  = i_pop && (r_cnt != '0);
        n_wp = r_wp + RQ_AW'(w0) + RQ_AW'(w1);
        n_rp = r_rp + RQ_AW'(pop);
        n_cnt = r_cnt + RQ_CW'(w0) + RQ_CW'(w1) - RQ_CW'(pop);
    end

    // head and flow control
    assign o_head  = r_q[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt > RQ_CW'(RQ_DEPTH - 2));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // slot writes
    always_ff @(posedge i_clk) begin
        if (w0) begin
            r_q[r_wp] <= rec0;
        end
        if (w1) begin
            r_q[wp1] <= i_emit.fin;
        end
    end

endmodule

/* rtl/core/stream_frame_indexer_unit.sv */
// ----------------------------------------------------------------------------
// stream_frame_indexer_unit
// Key-frame indexer over a recorded stream file, one file byte per beat.
// ----------------------------------------------------------------------------
// The block takes one byte every cycle: push is held off only when the
// four-entry result queue has fewer than two free places, which happens
// only while the result side stalls. A result is registered into the queue
// and shows on the result ports once it reaches the queue head; results
// drain at one per cycle from the queue while pop is held high. The parser
// settles each byte combinationally (position compare, header capture, next
// frame start add and end compare). There is no clearing pass after reset.
// Configuration writes are always ready and take effect from the next byte.
module stream_frame_indexer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_first_byte,
    input  logic                       i_last_byte,
    input  logic                       i_abort,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_result_kind,
    output logic [31:0]                o_frame_position,
    output logic [31:0]                o_frame_time,
    output logic [1:0]                 o_final_status,
    output logic [31:0]                o_entry_count,
    output logic [31:0]                o_first_time,
    output logic [31:0]                o_last_time,
    output logic                       o_last_of_run,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sfi_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                i_cfg_data
);
    import sfi_pkg::*;

    logic [31:0] r_begin_offset;
    logic [31:0] r_stream_length;
    logic        in_beat;
    t_emit       emit;
    t_result     head;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_offset  <= '0;
            r_stream_length <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BEGIN_OFFSET:  r_begin_offset  <= i_cfg_data;
                CFG_STREAM_LENGTH: r_stream_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input beat
    assign in_beat = push && !full;

    sfi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_beat),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .i_abort         (i_abort),
        .i_begin_offset  (r_begin_offset),
        .i_stream_length (r_stream_length),
        .o_emit          (emit)
    );

    sfi_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // result ports
    assign o_result_kind    = head.kind;
    assign o_frame_position = head.position;
    assign o_frame_time     = head.frame_time;
    assign o_final_status   = head.status;
    assign o_entry_count    = head.count;
    assign o_first_time     = head.first_time;
    assign o_last_time      = head.last_time;
    assign o_last_of_run    = head.last_of_run;

`ifndef SYNTHESIS
    // a final status always closes the run of its byte
    a_final_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == KIND_FINAL) |-> o_last_of_run)
        else $error("final status without last_of_run");

    // index entries carry no status and no time summary
    a_entry_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind == KIND_ENTRY) |->
        (o_final_status == ST_OK && o_first_time == 32'd0 && o_last_time == 32'd0))
        else $error("index entry with final fields set");

    // queue is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("result queue not empty after reset");

    // an empty queue stays empty unless a byte beat is taken
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !in_beat) |=> empty)
        else $error("result appeared without an input beat");
`endif

endmodule

/* tb/frame_index_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_index_checker
// Watches the byte, result and register channels of the frame indexer, keeps
// its own model of the header parser and compares every result beat, field by
// field, against the oldest predicted index entry or final status.
// ----------------------------------------------------------------------------
module frame_index_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_first_byte,
    input  logic                       i_last_byte,
    input  logic                       i_abort,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  sfi_pkg::t_result           i_result,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [sfi_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    input  logic                       i_end_check,
    output int                         o_outstanding,
    output int                         o_fail_count
);
    import sfi_pkg::*;

    // register copies
    logic [31:0] win_begin;
    logic [31:0] win_length;

    // parser state
    logic [31:0] byte_pos;
    logic [31:0] hdr_origin;
    logic [31:0] frame_start;
    logic [4:0]  hdr_fill;
    logic [7:0]  hdr_buf [HDR_LEN];
    logic [31:0] key_count;
    logic [31:0] key_time_first;
    logic [31:0] key_time_last;
    logic        index_closed;

    t_result     step_results[$];
    t_result     pending_results[$];
    int          result_beats;
    int          fail_total;

    initial begin
        fail_total    = 0;
        result_beats  = 0;
    end

    assign o_fail_count = fail_total;

    // one line per failure
    task automatic report_fail(input string msg);
        fail_total++;
        $display("[%0t] index check: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_fail($sformatf("result beat %0d %s got %0h expected %0h",
                                  result_beats, name, got, want));
    endtask

    // frame start that cannot hold a whole header
    function automatic logic no_room_for_header(input logic [63:0] at);
        logic [63:0] span;
        span = {32'd0, win_length};
        return (at >= span) || ((span - at) < HDR_LEN);
    endfunction

    function automatic logic [1:0] closing_status();
        return (key_count != 0) ? ST_OK : ST_NOKEY;
    endfunction

    task automatic clear_index();
        byte_pos       = '0;
        hdr_origin     = '0;
        frame_start    = '0;
        hdr_fill       = '0;
        key_count      = '0;
        key_time_first = '0;
        key_time_last  = '0;
        index_closed   = 1'b0;
    endtask

    task automatic close_index(input logic [1:0] st);
        t_result r;
        r            = '0;
        r.kind       = KIND_FINAL;
        r.status     = st;
        r.count      = key_count;
        r.first_time = key_time_first;
        r.last_time  = key_time_last;
        step_results.insert(step_results.size(), r);
        index_closed = 1'b1;
    endtask

    // results caused by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic first_b,
                                input logic last_b, input logic abort_b);
        logic [31:0] p;
        logic [31:0] tw;
        logic [63:0] after;
        logic        bad_type;
        t_result     r;
        step_results.delete();
        if (first_b) begin
            clear_index();
            byte_pos    = win_begin;
            frame_start = win_begin;
        end
        if (!index_closed) begin
            p = byte_pos;
            if (abort_b) begin
                close_index(ST_ABORT);
            end else if (hdr_fill == 0 && p == frame_start
                         && no_room_for_header({32'd0, p})) begin
                close_index(closing_status());
            end else begin
                if (hdr_fill != 0 || p == frame_start) begin
                    if (hdr_fill == 0) hdr_origin = p;
                    hdr_buf[hdr_fill[3:0]] = b;
                    hdr_fill = hdr_fill + 5'd1;
                    if (hdr_fill >= HDR_LEN) begin
                        hdr_fill = '0;
                        bad_type = 1'b0;
                        after    = '0;
                        // start code, then frame type
                        if (hdr_buf[0] != 8'h00 || hdr_buf[1] != 8'h00
                            || hdr_buf[2] != 8'h01) begin
                            if (({32'd0, win_length} - {32'd0, hdr_origin}) < TAIL_LEN
                                || hdr_origin >= win_length)
                                close_index(closing_status());
                            else
                                close_index(ST_BAD);
                        end else if (hdr_buf[3] == TYPE_KEY) begin
                            tw = {hdr_buf[11], hdr_buf[10], hdr_buf[9], hdr_buf[8]};
                            if (key_count == 0) key_time_first = tw;
                            key_time_last = tw;
                            if (key_count != 32'hFFFF_FFFF) key_count = key_count + 1;
                            r            = '0;
                            r.kind       = KIND_ENTRY;
                            r.position   = hdr_origin;
                            r.frame_time = tw;
                            r.count      = key_count;
                            step_results.insert(step_results.size(), r);
                            after = {32'd0, hdr_origin} + KEY_SKIP;
                        end else if (hdr_buf[3] == TYPE_SKIP) begin
                            after = {32'd0, hdr_origin} + HDR_LEN
                                  + {48'd0, hdr_buf[7], hdr_buf[6]};
                        end else begin
                            bad_type = 1'b1;
                        end
                        // next frame start or end of data
                        if (bad_type) begin
                            close_index(ST_BAD);
                        end else if (!index_closed) begin
                            if (no_room_for_header(after))
                                close_index(closing_status());
                            else
                                frame_start = after[31:0];
                        end
                    end
                end
                byte_pos = p + 32'd1;
                if (!index_closed && last_b) close_index(closing_status());
            end
        end
        foreach (step_results[i]) begin
            r             = step_results[i];
            r.last_of_run = (i == step_results.size() - 1);
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            win_begin  = '0;
            win_length = '0;
            clear_index();
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BEGIN_OFFSET:  win_begin  = i_cfg_data;
                    CFG_STREAM_LENGTH: win_length = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                result_beats++;
                if (pending_results.size() == 0) begin
                    report_fail($sformatf("result beat %0d with nothing pending",
                                          result_beats));
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", 32'(i_result.kind), 32'(want.kind));
                    check_field("frame_position", i_result.position, want.position);
                    check_field("frame_time", i_result.frame_time, want.frame_time);
                    check_field("final_status", 32'(i_result.status), 32'(want.status));
                    check_field("entry_count", i_result.count, want.count);
                    check_field("first_time", i_result.first_time, want.first_time);
                    check_field("last_time", i_result.last_time, want.last_time);
                    check_field("last_of_run", 32'(i_result.last_of_run),
                                32'(want.last_of_run));
                end
            end
            if (i_push && !i_full)
                predict_byte(i_data_byte, i_first_byte, i_last_byte, i_abort);
        end
        o_outstanding <= pending_results.size();
    end

    // anything still pending when the run ends
    always @(posedge i_end_check) begin
        if (pending_results.size() != 0)
            report_fail($sformatf("%0d results never arrived", pending_results.size()));
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams recorded-file byte images into the frame indexer: directed header,
// tail, abort and window cases first, then random files over random windows,
// with bursty input, a stalling result side and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import sfi_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_GAP    = 4;
    localparam int RANDOM_BEATS = 140;
    localparam int RANDOM_FILES = 4;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [7:0]        data_byte;
    logic              first_byte;
    logic              last_byte;
    logic              abort_req;
    logic              empty;
    logic              pop;
    logic              res_kind;
    logic [31:0]       res_position;
    logic [31:0]       res_time;
    logic [1:0]        res_status;
    logic [31:0]       res_count;
    logic [31:0]       res_first;
    logic [31:0]       res_last;
    logic              res_last_of_run;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [31:0]       cfg_data;
    logic              end_check;
    t_result           seen_result;
    int                outstanding;
    int                fail_count;

    // stimulus state
    logic [7:0]        file_img[$];
    bit                bursty;
    bit                hold_request;
    int                burst_left;
    int                beats_sent;

    stream_frame_indexer_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (data_byte),
        .i_first_byte     (first_byte),
        .i_last_byte      (last_byte),
        .i_abort          (abort_req),
        .empty            (empty),
        .pop              (pop),
        .o_result_kind    (res_kind),
        .o_frame_position (res_position),
        .o_frame_time     (res_time),
        .o_final_status   (res_status),
        .o_entry_count    (res_count),
        .o_first_time     (res_first),
        .o_last_time      (res_last),
        .o_last_of_run    (res_last_of_run),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    assign seen_result = {res_kind, res_position, res_time, res_status, res_count,
                          res_first, res_last, res_last_of_run};

    frame_index_checker index_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_data_byte   (data_byte),
        .i_first_byte  (first_byte),
        .i_last_byte   (last_byte),
        .i_abort       (abort_req),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_result      (seen_result),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_end_check   (end_check),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: changing stall patterns plus one long hold-off on request
    initial begin : result_drain
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        pop       = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 1);
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // one byte beat, called at a falling edge; returns at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic fb, input logic lb,
                             input logic ab);
        push       <= 1'b1;
        data_byte  <= b;
        first_byte <= fb;
        last_byte  <= lb;
        abort_req  <= ab;
        do @(posedge clk); while (full);
        @(negedge clk);
        beats_sent++;
        if (bursty) begin
            if (burst_left == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_file(input bit with_first, input int abort_at, input bit with_last);
        foreach (file_img[i])
            send_beat(file_img[i], with_first && i == 0,
                      with_last && i == file_img.size() - 1, i == abort_at);
    endtask

    // wait for every pending result, then for the parser to go quiet
    task automatic settle();
        push <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic load_window(input logic [31:0] start, input logic [31:0] span_end);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BEGIN_OFFSET;
        cfg_data  <= start;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_STREAM_LENGTH;
        cfg_data  <= span_end;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // append one byte to the file image
    task automatic put_byte(input logic [7:0] b);
        file_img.insert(file_img.size(), b);
    endtask

    task automatic put_noise(input int n);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
    endtask

    // 16-byte frame header: start code, type, length in 6..7, time in 8..11
    task automatic put_header(input logic [7:0] kind, input logic [15:0] len,
                              input logic [31:0] tw);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(kind);
        put_noise(2);
        put_byte(len[7:0]);
        put_byte(len[15:8]);
        put_byte(tw[7:0]);
        put_byte(tw[15:8]);
        put_byte(tw[23:16]);
        put_byte(tw[31:24]);
        put_noise(4);
    endtask

    task automatic put_key_frame(input logic [31:0] tw, input bit with_body);
        put_header(TYPE_KEY, 16'($urandom), tw);
        if (with_body) put_noise(KEY_SKIP - HDR_LEN);
    endtask

    task automatic put_skip_frame(input logic [15:0] len, input bit with_body);
        put_header(TYPE_SKIP, len, $urandom);
        if (with_body) put_noise(int'(len));
    endtask

    // header with a broken start code or an unknown type
    task automatic put_bad_header(input bit bad_code);
        logic [7:0] kind;
        int         base;
        base = file_img.size();
        kind = 8'($urandom_range(0, 239));
        put_header(bad_code ? TYPE_KEY : kind, 16'($urandom), $urandom);
        if (bad_code)
            file_img[base + $urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
    endtask

    // mostly well-formed frame chains with random content
    task automatic build_random_file();
        int          nfr;
        int          r;
        logic [15:0] len;
        file_img.delete();
        nfr = $urandom_range(1, 4);
        for (int k = 0; k < nfr; k++) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                len = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
                put_skip_frame(len, len <= 24);
            end else if (r < 8) begin
                // bytes after a key frame header fall in its body
                put_key_frame($urandom, 1'b0);
                break;
            end else if (r == 8) begin
                put_bad_header($urandom_range(0, 1) == 1);
            end else begin
                put_noise($urandom_range(1, 8));
            end
        end
        put_noise($urandom_range(0, 4));
    endtask

    // main stimulus
    initial begin : stimulus
        logic [31:0] start;
        logic [31:0] span;
        int          files_left;
        int          files_sent;
        int          random_start;
        int          wait_cnt;
        push         = 1'b0;
        data_byte    = '0;
        first_byte   = 1'b0;
        last_byte    = 1'b0;
        abort_req    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_BEGIN_OFFSET;
        cfg_data     = '0;
        end_check    = 1'b0;
        hold_request = 1'b0;
        bursty       = 1'b1;
        burst_left   = 0;
        beats_sent   = 0;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no new-file flag after reset: parse from position zero
        load_window(32'd0, 32'd48);
        file_img.delete();
        put_skip_frame(16'd0, 1'b1);
        put_key_frame(32'hFFFF_FFFF, 1'b0);
        send_file(1'b0, -1, 1'b0);

        // key frame at the start, trailing bytes ignored
        file_img.delete();
        put_key_frame(32'h0000_0000, 1'b0);
        put_noise(4);
        send_file(1'b1, -1, 1'b1);

        // bad start code and unknown type away from the tail
        load_window(32'd0, 32'd5000);
        file_img.delete();
        put_bad_header(1'b1);
        send_file(1'b1, -1, 1'b0);
        file_img.delete();
        put_header(8'h00, 16'd0, 32'd0);
        send_file(1'b1, -1, 1'b0);
        file_img.delete();
        put_header(8'hFF, 16'd0, 32'd0);
        send_file(1'b1, -1, 1'b0);

        // maximum skip length runs past the end
        file_img.delete();
        put_skip_frame(16'hFFFF, 1'b0);
        send_file(1'b1, -1, 1'b0);

        // abort inside a key frame body
        file_img.delete();
        put_key_frame(32'hA5A5_5A5A, 1'b0);
        put_noise(8);
        send_file(1'b1, 20, 1'b1);

        // abort on the first byte, rest ignored, last byte and a later abort included
        file_img.delete();
        put_noise(3);
        send_file(1'b1, 0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1, 1'b1);

        // last byte on the header byte that completes a key frame
        file_img.delete();
        put_key_frame(32'h0123_4567, 1'b0);
        send_file(1'b1, -1, 1'b1);

        // last byte mid-header, then a new file restarts mid-header
        file_img.delete();
        put_noise(7);
        send_file(1'b1, -1, 1'b1);
        file_img.delete();
        put_header(TYPE_KEY, 16'd0, 32'd0);
        file_img = file_img[0:7];
        send_file(1'b1, -1, 1'b0);
        file_img.delete();
        put_skip_frame(16'd3, 1'b1);
        send_file(1'b1, -1, 1'b1);

        // bad start code in the tail after a skipped frame
        load_window(32'd0, 32'd1040);
        file_img.delete();
        put_skip_frame(16'd4, 1'b1);
        put_bad_header(1'b1);
        send_file(1'b1, -1, 1'b0);

        // tail boundary: exactly 1024 left is still a bad header
        load_window(32'd0, 32'd1024);
        file_img.delete();
        put_bad_header(1'b1);
        send_file(1'b1, -1, 1'b0);
        load_window(32'd0, 32'd1023);
        send_file(1'b1, -1, 1'b0);

        // window too short, and begin past the length
        load_window(32'd100, 32'd110);
        send_beat(8'h00, 1'b1, 1'b0, 1'b0);
        load_window(32'd200, 32'd100);
        send_beat(8'h00, 1'b1, 1'b0, 1'b0);

        // exactly sixteen bytes left, then fifteen
        load_window(32'd0, 32'd36);
        file_img.delete();
        put_skip_frame(16'd4, 1'b1);
        put_key_frame(32'h7FFF_FFFF, 1'b0);
        send_file(1'b1, -1, 1'b0);
        file_img.delete();
        put_skip_frame(16'd5, 1'b1);
        put_noise(16);
        send_file(1'b1, -1, 1'b1);

        // next frame start beyond 32 bits, and begin at the top of the range
        load_window(32'hFFFF_FBF0, 32'hFFFF_FFFF);
        file_img.delete();
        put_key_frame(32'h8000_0000, 1'b0);
        send_file(1'b1, -1, 1'b0);
        load_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(8'hFF, 1'b1, 1'b0, 1'b0);

        // skipped frame then a key frame, ended by last byte
        load_window(32'd0, 32'hFFFF_FFFF);
        file_img.delete();
        put_skip_frame(16'd5, 1'b1);
        put_key_frame(32'h8000_0001, 1'b0);
        put_noise(3);
        send_file(1'b1, -1, 1'b1);

        // result hold-off while one-byte files keep coming
        load_window(32'd50, 32'd60);
        bursty       = 1'b0;
        hold_request = 1'b1;
        repeat (12) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);

        // random files over random windows
        files_left   = 0;
        files_sent   = 0;
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS || files_sent < RANDOM_FILES) begin
            if (files_left == 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        start = $urandom;
                        span  = $urandom_range(2100, 4200);
                    end
                    1: begin
                        start = 32'hFFFF_FFFF - $urandom_range(0, 300);
                        span  = $urandom_range(0, 300);
                    end
                    2: begin
                        start = 32'd0;
                        span  = $urandom_range(0, 120);
                    end
                    default: begin
                        start = $urandom;
                        span  = $urandom_range(20, 160);
                    end
                endcase
                load_window(start, start + span);
                bursty     = ($urandom_range(0, 3) != 0);
                files_left = $urandom_range(1, 3);
            end
            build_random_file();
            send_file($urandom_range(0, 14) != 0,
                      ($urandom_range(0, 11) == 0) ? $urandom_range(0, file_img.size() - 1) : -1,
                      $urandom_range(0, 3) != 0);
            files_left--;
            files_sent++;
        end

        // drain and verdict
        push <= 1'b0;
        wait_cnt = 0;
        while (outstanding != 0 && wait_cnt < 5000) begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (8) @(negedge clk);
        end_check <= 1'b1;
        @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
